// File: rtl/core/fat12cw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fat12cw_pkg;

   localparam int FAT_ENTRIES = 4096;
   localparam int MAX_CHAIN   = 64;
   localparam int FAT_IDX_W   = $clog2(FAT_ENTRIES);

   localparam logic [11:0] END_MARK   = 12'hFF0;
   localparam logic [11:0] BEYOND_FAT = 12'hFFF;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_WALK = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [7:0]  data_byte;
      logic [11:0] head_cluster;
   } req_type;

   typedef struct packed {
      logic [11:0] cluster_number;
      logic [16:0] cluster_address;
      logic [16:0] next_address;
      logic [5:0]  link_index;
      logic        last_link;
      logic        truncated;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/core/fat12_chain_walker.sv
`timescale 1ns / 1ps
`default_nettype none

// load transfer: busy never rises; a byte may follow on every cycle while no walk is busy
// walk transfer: busy until the last link is issued, up to 64 links; none for an end-mark start
// first link: head entry goes to the read register, then the link to the response register; then one per cycle
// results cannot be held off, so a walk never stalls once started
// reset (sync, active high) clears the sequencer, strobe and unpack state, sets base sector to 33; table not cleared
module fat12_chain_walker (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       start,
   output logic                      busy,
   input  wire fat12cw_pkg::req_type req_item,
   output logic                      rsp_strobe,
   output fat12cw_pkg::rsp_type      rsp_item,
   input  wire                       csr_write_enable,
   input  wire  [15:0]               csr_write_data
);

   localparam int IDX_W = fat12cw_pkg::FAT_IDX_W;

   // walk sequencer codes
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LINK = 1'b1;

   localparam logic [1:0] PH_LOW  = 2'd0;
   localparam logic [1:0] PH_MID  = 2'd1;
   localparam logic [1:0] PH_HIGH = 2'd2;

   // table store, sync read
   logic [11:0] fat_mem [fat12cw_pkg::FAT_ENTRIES];

   logic             state_ff, state_in;
   logic [1:0]       phase_ff, phase_in;
   logic [7:0]       held_ff, held_in;
   logic [IDX_W-1:0] load_ptr_ff, load_ptr_in;
   logic [15:0]      base_sector_ff;
   logic [11:0]      cur_ff, cur_in;
   logic [5:0]       link_ff, link_in;
   logic [11:0]      rd_data_ff;
   logic             strobe_ff, strobe_in;
   fat12cw_pkg::rsp_type rsp_ff, rsp_in;

   logic             accept;
   logic             wr_en;
   logic [11:0]      wr_data;
   logic [IDX_W-1:0] rd_addr;
   logic [11:0]      nxt;
   logic             chain_end, chain_trunc, stop;

   assign accept = start && !busy;
   assign busy   = (state_ff == ST_LINK);

   // ---------------------------------------------------------------- load path
   // three bytes unpack into two 12-bit entries, little-endian packing
   always_comb begin
      wr_en       = 1'b0;
      wr_data     = 12'd0;
      phase_in    = phase_ff;
      held_in     = held_ff;
      load_ptr_in = load_ptr_ff;
      if (accept && req_item.operation == fat12cw_pkg::OP_LOAD) begin
         case (phase_ff)
            PH_LOW: begin
               held_in  = req_item.data_byte;
               phase_in = PH_MID;
            end
            PH_MID: begin
               wr_en    = 1'b1;
               wr_data  = {req_item.data_byte[3:0], held_ff};
               held_in  = {4'd0, req_item.data_byte[7:4]};
               phase_in = PH_HIGH;
            end
            default: begin
               wr_en    = 1'b1;
               wr_data  = {req_item.data_byte, held_ff[3:0]};
               held_in  = 8'd0;
               phase_in = PH_LOW;
            end
         endcase
         if (wr_en) begin
            // wraps to the start once the last entry is written
            if ({1'b0, load_ptr_ff} == (IDX_W + 1)'(fat12cw_pkg::FAT_ENTRIES - 1)) begin
               load_ptr_in = '0;
            end else begin
               load_ptr_in = load_ptr_ff + 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------- walk path
   // a cluster past the table reads as an end mark
   always_comb begin
      if ({1'b0, cur_ff} >= 13'(fat12cw_pkg::FAT_ENTRIES)) begin
         nxt = fat12cw_pkg::BEYOND_FAT;
      end else begin
         nxt = rd_data_ff;
      end
      chain_end   = (nxt >= fat12cw_pkg::END_MARK);
      chain_trunc = !chain_end && (link_ff == 6'(fat12cw_pkg::MAX_CHAIN - 1));
      stop        = chain_end || chain_trunc;
   end

   // read address: first cluster while idle, the fetched link while walking
   always_comb begin
      if (state_ff == ST_LINK) begin
         rd_addr = nxt[IDX_W-1:0];
      end else begin
         rd_addr = req_item.head_cluster[IDX_W-1:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      link_in   = link_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            // a first cluster at an end mark transfers but gives nothing
            if (accept && req_item.operation == fat12cw_pkg::OP_WALK &&
                req_item.head_cluster < fat12cw_pkg::END_MARK) begin
               state_in = ST_LINK;
               cur_in   = req_item.head_cluster;
               link_in  = 6'd0;
            end
         end
         ST_LINK: begin
            strobe_in               = 1'b1;
            rsp_in.cluster_number   = cur_ff;
            rsp_in.cluster_address  = 17'(base_sector_ff) + 17'(cur_ff) - 17'd2;
            rsp_in.next_address     = stop ? 17'd0
                                           : 17'(base_sector_ff) + 17'(nxt) - 17'd2;
            rsp_in.link_index       = link_ff;
            rsp_in.last_link        = stop;
            rsp_in.truncated        = chain_trunc;
            cur_in                  = nxt;
            link_in                 = link_ff + 6'd1;
            if (stop) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         fat_mem[load_ptr_ff] <= wr_data;
      end
      rd_data_ff <= fat_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         phase_ff       <= PH_LOW;
         held_ff        <= 8'd0;
         load_ptr_ff    <= '0;
         base_sector_ff <= 16'd33;
         strobe_ff      <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         held_ff   <= held_in;
         load_ptr_ff <= load_ptr_in;
         strobe_ff <= strobe_in;
         if (csr_write_enable) begin
            base_sector_ff <= csr_write_data;
         end
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      link_ff <= link_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/core/fat12cw_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module fat12cw_checker (
   input wire                       clock,
   input wire                       reset,
   input wire                       start,
   input wire                       busy,
   input wire fat12cw_pkg::req_type req_item,
   input wire                       rsp_strobe,
   input wire fat12cw_pkg::rsp_type rsp_item
);

   // truncation only on the closing link
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.truncated |-> rsp_item.last_link)
      else $error("truncated flag on a non-final link");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.last_link |-> rsp_item.next_address == 17'd0)
      else $error("final link carries a next address");

   // links of one walk come on back-to-back cycles with rising index
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last_link |=>
         rsp_strobe && rsp_item.link_index == $past(rsp_item.link_index) + 6'd1)
      else $error("walk links not contiguous");

   // a load transfer never holds off the next one
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.operation == fat12cw_pkg::OP_LOAD |=> !busy)
      else $error("busy after a load transfer");

endmodule

bind fat12_chain_walker fat12cw_checker u_fat12cw_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

`default_nettype wire
